FILE: rtl/core/hsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsq_pkg
// Shared types and codes of the two-speed homing sequencer.
// ----------------------------------------------------------------------------
package hsq_pkg;

    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned DIST_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MOVE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MOVE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_MOVE = 3'd4;

    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_ENABLE  = 2'd1;
    localparam logic [1:0] DRV_DISABLE = 2'd2;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_FAST_START    = 3'd0,
        PH_FAST_SEEK     = 3'd1,
        PH_BACKOFF1      = 3'd2,
        PH_SLOW_SEEK     = 3'd3,
        PH_FINAL_BACKOFF = 3'd4,
        PH_ERROR         = 3'd5,
        PH_DONE          = 3'd6
    } t_phase;

    typedef struct packed {
        logic action;
        logic sensor_pressed;
        logic target_reached;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               driver_cmd;
        logic                     speed_valid;
        logic [SPEED_W-1:0]       speed_value;
        logic                     move_valid;
        logic signed [DIST_W-1:0] move_distance;
        logic                     step_enable;
        logic                     cut_motion;
        logic                     stop_motion;
        logic                     zero_position;
        logic                     finished;
        logic                     failed;
    } t_out_word;

    typedef struct packed {
        logic [SPEED_W-1:0]       fast_speed;
        logic [SPEED_W-1:0]       slow_speed;
        logic signed [DIST_W-1:0] long_move;
        logic signed [DIST_W-1:0] backoff_move;
        logic signed [DIST_W-1:0] approach_move;
    } t_cfg;

endpackage
`default_nettype wire

FILE: rtl/core/hsq_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsq_cfg_regs
// Configuration register file: speeds and move distances.
// ----------------------------------------------------------------------------
module hsq_cfg_regs
    import hsq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_FAST_SPEED:    r_cfg.fast_speed    <= i_data[SPEED_W-1:0];
                CFG_SLOW_SPEED:    r_cfg.slow_speed    <= i_data[SPEED_W-1:0];
                CFG_LONG_MOVE:     r_cfg.long_move     <= $signed(i_data[DIST_W-1:0]);
                CFG_BACKOFF_MOVE:  r_cfg.backoff_move  <= $signed(i_data[DIST_W-1:0]);
                CFG_APPROACH_MOVE: r_cfg.approach_move <= $signed(i_data[DIST_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: rtl/core/hsq_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsq_seq
// Homing state machine: phase register and the command word of each tick.
// ----------------------------------------------------------------------------
module hsq_seq
    import hsq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_word  i_word,
    input  wire t_cfg      i_cfg,
    output t_out_word      o_word
);

    t_phase r_phase, n_phase;
    logic   r_first_entry, n_first_entry;
    logic   r_error_flag, n_error_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FAST_START;
            r_first_entry <= 1'b1;
            r_error_flag  <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_first_entry <= n_first_entry;
            r_error_flag  <= n_error_flag;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_first_entry = r_first_entry;
        n_error_flag  = r_error_flag;
        o_word        = '0;
        if (i_word.action == ACT_RESTART) begin
            n_phase       = PH_FAST_START;
            n_first_entry = 1'b1;
            n_error_flag  = 1'b0;
        end else begin
            unique case (r_phase)
                PH_FAST_START: begin
                    o_word.driver_cmd    = DRV_ENABLE;
                    o_word.speed_valid   = 1'b1;
                    o_word.speed_value   = i_cfg.fast_speed;
                    o_word.move_valid    = 1'b1;
                    o_word.move_distance = i_cfg.long_move;
                    n_phase              = PH_FAST_SEEK;
                end
                PH_FAST_SEEK: begin
                    o_word.step_enable = 1'b1;
                    if (i_word.sensor_pressed) begin
                        o_word.cut_motion = 1'b1;
                        n_first_entry     = 1'b1;
                        n_phase           = PH_BACKOFF1;
                    end
                end
                PH_BACKOFF1, PH_FINAL_BACKOFF: begin
                    o_word.step_enable = 1'b1;
                    if (r_first_entry) begin
                        o_word.speed_valid   = 1'b1;
                        o_word.speed_value   = i_cfg.slow_speed;
                        o_word.move_valid    = 1'b1;
                        o_word.move_distance = i_cfg.backoff_move;
                        n_first_entry        = 1'b0;
                    end else if (i_word.target_reached) begin
                        o_word.stop_motion = 1'b1;
                        if (i_word.sensor_pressed) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_first_entry = 1'b1;
                            n_phase = (r_phase == PH_BACKOFF1) ? PH_SLOW_SEEK : PH_DONE;
                        end
                    end
                end
                PH_SLOW_SEEK: begin
                    o_word.step_enable = 1'b1;
                    if (r_first_entry) begin
                        o_word.speed_valid   = 1'b1;
                        o_word.speed_value   = i_cfg.slow_speed;
                        o_word.move_valid    = 1'b1;
                        o_word.move_distance = i_cfg.approach_move;
                        n_first_entry        = 1'b0;
                    end
                    if (i_word.sensor_pressed) begin
                        o_word.cut_motion    = 1'b1;
                        o_word.zero_position = 1'b1;
                        n_first_entry        = 1'b1;
                        n_phase              = PH_FINAL_BACKOFF;
                    end
                end
                PH_DONE: begin
                    o_word.driver_cmd = DRV_DISABLE;
                    o_word.finished   = 1'b1;
                end
                default: begin
                    o_word.driver_cmd = DRV_DISABLE;
                    o_word.cut_motion = 1'b1;
                    o_word.finished   = 1'b1;
                    n_error_flag      = 1'b1;
                end
            endcase
            o_word.failed = n_error_flag;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hsq_out_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsq_out_skid
// Result register with one skid word, so the input side runs at full rate while the skid word is empty.
// ----------------------------------------------------------------------------
module hsq_out_skid
    import hsq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_word,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_word
);

    logic      r_out_valid, r_skid_valid;
    t_out_word r_out_word, r_skid_word;
    logic      take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_word <= i_word;
            end else begin
                r_skid_word <= i_word;
            end
        end else if (take && r_skid_valid) begin
            r_out_word <= r_skid_word;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule
`default_nettype wire

FILE: rtl/core/two_speed_homing_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_speed_homing_sequencer
// Two-speed limit-switch homing sequencer, top level.
// ----------------------------------------------------------------------------
// Each accepted word is either a tick or a restart, and each yields exactly one
// command word, registered in the result register or its skid word. A new
// word is taken every cycle; the input stalls only when the result register
// and its single skid word are both full, so the rate is one word per cycle
// whenever the output side keeps up. Configuration writes are always ready
// and take effect on the next accepted word.
// ----------------------------------------------------------------------------
module two_speed_homing_sequencer
    import hsq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_word seq_word;
    logic      in_accept;
    logic      skid_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = skid_full;
    assign in_accept   = i_in_valid && !skid_full;

    hsq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hsq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .o_word   (seq_word)
    );

    hsq_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_word  (seq_word),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule
`default_nettype wire

FILE: dv/hsq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsq_checker
// Command word predictor and scoreboard for the two-speed homing sequencer.
// ----------------------------------------------------------------------------
// Watches the word, command and register channels at every rising edge. Each
// accepted word runs through a copy of the sequencer kept here, and the
// predicted command word is queued. Every accepted command word is compared
// field by field with the oldest prediction, and each difference is counted
// and reported.
// ----------------------------------------------------------------------------
module hsq_checker
    import hsq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_words_checked,
    output int                   o_done_words,
    output int                   o_error_words
);

    t_cfg      regs_q;
    t_phase    phase_q;
    logic      first_entry_q;
    logic      error_q;
    t_out_word expected_cmds[$];

    function automatic void with_move(inout t_out_word c, input logic [SPEED_W-1:0] speed,
                                      input logic signed [DIST_W-1:0] distance);
        c.speed_valid   = 1'b1;
        c.speed_value   = speed;
        c.move_valid    = 1'b1;
        c.move_distance = distance;
    endfunction

    function automatic t_out_word predict_command(input t_in_word w);
        t_out_word c;
        logic      entering;
        c = '0;
        if (w.action == ACT_RESTART) begin
            phase_q       = PH_FAST_START;
            first_entry_q = 1'b1;
            error_q       = 1'b0;
            return c;
        end
        case (phase_q)
            PH_FAST_START: begin
                c.driver_cmd = DRV_ENABLE;
                with_move(c, regs_q.fast_speed, regs_q.long_move);
                phase_q = PH_FAST_SEEK;
            end
            PH_FAST_SEEK: begin
                c.step_enable = 1'b1;
                if (w.sensor_pressed) begin
                    c.cut_motion  = 1'b1;
                    first_entry_q = 1'b1;
                    phase_q       = PH_BACKOFF1;
                end
            end
            PH_BACKOFF1, PH_FINAL_BACKOFF: begin
                entering = first_entry_q;
                if (entering) begin
                    with_move(c, regs_q.slow_speed, regs_q.backoff_move);
                    first_entry_q = 1'b0;
                end
                c.step_enable = 1'b1;
                if (!entering && w.target_reached) begin
                    c.stop_motion = 1'b1;
                    if (!w.sensor_pressed) begin
                        first_entry_q = 1'b1;
                        phase_q = (phase_q == PH_BACKOFF1) ? PH_SLOW_SEEK : PH_DONE;
                    end else begin
                        phase_q = PH_ERROR;
                    end
                end
            end
            PH_SLOW_SEEK: begin
                if (first_entry_q) begin
                    with_move(c, regs_q.slow_speed, regs_q.approach_move);
                    first_entry_q = 1'b0;
                end
                c.step_enable = 1'b1;
                if (w.sensor_pressed) begin
                    c.cut_motion    = 1'b1;
                    c.zero_position = 1'b1;
                    first_entry_q   = 1'b1;
                    phase_q         = PH_FINAL_BACKOFF;
                end
            end
            PH_DONE: begin
                c.driver_cmd = DRV_DISABLE;
                c.finished   = 1'b1;
            end
            default: begin
                c.driver_cmd = DRV_DISABLE;
                c.cut_motion = 1'b1;
                error_q      = 1'b1;
                c.finished   = 1'b1;
            end
        endcase
        c.failed = error_q;
        return c;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DAT_W-1:0] data);
        case (index)
            CFG_FAST_SPEED:    regs_q.fast_speed    = data[SPEED_W-1:0];
            CFG_SLOW_SPEED:    regs_q.slow_speed    = data[SPEED_W-1:0];
            CFG_LONG_MOVE:     regs_q.long_move     = data[DIST_W-1:0];
            CFG_BACKOFF_MOVE:  regs_q.backoff_move  = data[DIST_W-1:0];
            CFG_APPROACH_MOVE: regs_q.approach_move = data[DIST_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            o_mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    function automatic void compare_command(input t_out_word want, input t_out_word got);
        check_field("driver_cmd", want.driver_cmd, got.driver_cmd);
        check_field("speed_valid", want.speed_valid, got.speed_valid);
        check_field("speed_value", want.speed_value, got.speed_value);
        check_field("move_valid", want.move_valid, got.move_valid);
        check_field("move_distance", DIST_W'(want.move_distance), DIST_W'(got.move_distance));
        check_field("step_enable", want.step_enable, got.step_enable);
        check_field("cut_motion", want.cut_motion, got.cut_motion);
        check_field("stop_motion", want.stop_motion, got.stop_motion);
        check_field("zero_position", want.zero_position, got.zero_position);
        check_field("finished", want.finished, got.finished);
        check_field("failed", want.failed, got.failed);
        o_words_checked++;
        if (want.finished && want.failed) begin
            o_error_words++;
        end else if (want.finished) begin
            o_done_words++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            regs_q        = '0;
            phase_q       = PH_FAST_START;
            first_entry_q = 1'b1;
            error_q       = 1'b0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: command word expected none, got %h", $time, i_out_word);
                end else begin
                    want = expected_cmds.pop_front();
                    compare_command(want, i_out_word);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_cmds.push_back(predict_command(i_in_word));
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the two-speed homing sequencer.
// ----------------------------------------------------------------------------
// Writes the speed and distance registers at several settings, the extremes
// among them, and drives tick and restart words: a short directed walk through
// the clean, failing and terminal paths, then random homing runs with random
// content mixed with noise. Both sides idle and stall at random; once the
// receiver holds off long enough to back the block up. A checker beside the
// block predicts and compares every command word.
// ----------------------------------------------------------------------------
module tb_top;
    import hsq_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 1500;
    localparam int SETTINGS_N   = 6;
    localparam int LONG_HOLD    = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_word            out_word;
    logic                 cfg_ready;

    int mismatches;
    int pending;
    int words_checked;
    int done_words;
    int error_words;
    int cycle_count     = 0;
    int words_sent      = 0;
    int restarts_sent   = 0;
    int reg_writes      = 0;
    int settings_loaded = 0;
    int gap_max         = 15;
    int busy_max        = 15;
    int rx_hold_cycles  = 0;

    two_speed_homing_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hsq_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_done_words    (done_words),
        .o_error_words   (error_words)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        forever begin
            if (rx_hold_cycles > 0) begin
                out_stall = 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end else begin
                int busy;
                busy = $urandom_range(0, busy_max);
                if (busy > 0) begin
                    out_stall = 1'b1;
                    repeat (busy) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_word(input logic action, input logic sensor, input logic reached);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  = '{action, sensor, reached};
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        words_sent++;
        if (action == ACT_RESTART) begin
            restarts_sent++;
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        reg_writes++;
    endtask

    // Speed writes carry random upper bits, which the block must ignore.
    task automatic load_config(input logic [SPEED_W-1:0] fast_v, slow_v,
                               input logic [DIST_W-1:0] seek_d, backoff_d, approach_d);
        write_reg(CFG_FAST_SPEED, {8'($urandom), fast_v});
        write_reg(CFG_SLOW_SPEED, {8'($urandom), slow_v});
        write_reg(CFG_LONG_MOVE, seek_d);
        write_reg(CFG_BACKOFF_MOVE, backoff_d);
        write_reg(CFG_APPROACH_MOVE, approach_d);
        cfg_valid = 1'b0;
        settings_loaded++;
    endtask

    task automatic run_backoff(output logic cleared);
        cleared = ($urandom_range(0, 9) != 0);
        send_word(ACT_TICK, coin(), coin());
        repeat ($urandom_range(0, 5)) send_word(ACT_TICK, coin(), 1'b0);
        send_word(ACT_TICK, !cleared, 1'b1);
    endtask

    // Mostly complete homing runs with random waits and an occasional failed
    // clear check; the rest is random ticks with sparse restarts.
    task automatic run_episode();
        logic cleared;
        int   pct;
        if ($urandom_range(0, 19) == 0) begin
            drain();
        end
        send_word(ACT_RESTART, coin(), coin());
        if ($urandom_range(0, 9) < 7) begin
            send_word(ACT_TICK, coin(), coin());
            repeat ($urandom_range(0, 6)) send_word(ACT_TICK, 1'b0, coin());
            send_word(ACT_TICK, 1'b1, coin());
            run_backoff(cleared);
            if (cleared) begin
                repeat ($urandom_range(0, 6)) send_word(ACT_TICK, 1'b0, coin());
                send_word(ACT_TICK, 1'b1, coin());
                run_backoff(cleared);
            end
            repeat ($urandom_range(1, 4)) send_word(ACT_TICK, coin(), coin());
        end else begin
            pct = $urandom_range(5, 60);
            repeat ($urandom_range(3, 40)) begin
                if ($urandom_range(0, 32) == 0) begin
                    send_word(ACT_RESTART, coin(), coin());
                end else begin
                    send_word(ACT_TICK, $urandom_range(0, 99) < pct, coin());
                end
            end
        end
    endtask

    initial begin
        int phase_end;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        load_config(16'd1200, 16'd300, -24'sd200000, 24'sd1600, -24'sd3200);

        // Clean run to done; back-offs are entered while target_reached is high.
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_RESTART, 1'b1, 1'b1);
        // The switch stays pressed after the first back-off.
        send_word(ACT_TICK, 1'b0, 1'b0);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b0);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b0);
        send_word(ACT_RESTART, 1'b0, 1'b0);
        // Slow seek waits one tick, then the final clear check fails.
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b0, 1'b0);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_TICK, 1'b1, 1'b0);
        send_word(ACT_TICK, 1'b1, 1'b1);
        send_word(ACT_TICK, 1'b0, 1'b0);
        send_word(ACT_RESTART, 1'b0, 1'b1);

        for (int p = 0; p < SETTINGS_N; p++) begin
            drain();
            case (p)
                0: begin
                    load_config(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
                    gap_max  = 15;
                    busy_max = 15;
                end
                1: begin
                    load_config(16'h0000, 16'h0000, 24'h800000, 24'h800000, 24'h800000);
                    gap_max        = 0;
                    busy_max       = 0;
                    rx_hold_cycles = LONG_HOLD;
                end
                2: begin
                    load_config('0, '0, '0, '0, '0);
                    gap_max  = 15;
                    busy_max = 0;
                end
                3: begin
                    load_config(SPEED_W'($urandom), SPEED_W'($urandom), DIST_W'($urandom),
                                DIST_W'($urandom), DIST_W'($urandom));
                    gap_max  = 0;
                    busy_max = 15;
                end
                4: begin
                    load_config(16'hFFFF, 16'h0000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
                    gap_max  = 3;
                    busy_max = 3;
                end
                default: begin
                    write_reg(CFG_UNUSED_IDX, CFG_DAT_W'($urandom));
                    load_config(SPEED_W'($urandom), SPEED_W'($urandom), DIST_W'($urandom),
                                DIST_W'($urandom), DIST_W'($urandom));
                    gap_max  = 15;
                    busy_max = 15;
                end
            endcase
            phase_end = words_sent + RANDOM_WORDS / SETTINGS_N;
            while (words_sent < phase_end) begin
                run_episode();
            end
        end

        drain();
        repeat (8) @(negedge clk);
        $display("Covered %0d words (%0d restarts) under %0d register settings, %0d writes.",
                 words_sent, restarts_sent, settings_loaded, reg_writes);
        $display("Checked %0d command words: %0d in the done phase, %0d in the error phase.",
                 words_checked, done_words, error_words);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
